// ----- rtl/core/lru_page_residency_table_macros.svh -----
// Assertion helpers for the page residency table.
`ifndef LRU_PAGE_RESIDENCY_TABLE_MACROS_SVH
`define LRU_PAGE_RESIDENCY_TABLE_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define PRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("prt assertion failed");

// Next-cycle implication, off while reset is asserted.
`define PRT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("prt assertion failed");

`endif

// ----- rtl/core/prt_pkg.sv -----
`timescale 1ns / 1ps
package prt_pkg;

	typedef enum logic [2:0] {
		OP_ENSURE = 3'd0,
		OP_SETPIN = 3'd1,
		OP_DIRTY  = 3'd2,
		OP_CLEAN  = 3'd3,
		OP_LOOKUP = 3'd4,
		OP_CLEAR  = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_HIT      = 3'd0,
		ST_FREE     = 3'd1,
		ST_EVICT    = 3'd2,
		ST_NOSLOT   = 3'd3,
		ST_NOTFOUND = 3'd4,
		ST_DONE     = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLR,
		S_SCAN,
		S_DRAIN,
		S_DONE
	} state_t;

	// scan unit control
	typedef struct packed {
		logic clr;
		logic vld;
	} scan_ctl_t;

	// what the scan has found so far
	typedef struct packed {
		logic hit;
		logic free;
		logic vict;
	} scan_flags_t;

	// entry word layout: {valid, pinned, dirty, key, generation, last_use}
	localparam int LU_W    = 32;
	localparam int GEN_W   = 32;
	localparam int DIRTY_W = 8;
	localparam int LU_LSB  = 0;
	localparam int GEN_LSB = LU_LSB + LU_W;
	localparam int KEY_LSB = GEN_LSB + GEN_W;
	localparam int SLOT_OUT_W = 6;

endpackage

// ----- rtl/core/prt_req_if.sv -----
`timescale 1ns / 1ps
interface prt_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [31:0] page_key;
	logic        pin_flag;
	logic [7:0]  plane_mask;

	modport source (output valid, op, page_key, pin_flag, plane_mask, input ready);
	modport sink (input valid, op, page_key, pin_flag, plane_mask, output ready);
endinterface

// ----- rtl/core/prt_rsp_if.sv -----
`timescale 1ns / 1ps
interface prt_rsp_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic [2:0]  status;
	logic [5:0]  slot_index;
	logic [31:0] page_generation;
	logic [7:0]  dirty_bits;
	logic        is_pinned;
	logic [31:0] table_version;

	modport source (output valid, ok, status, slot_index, page_generation, dirty_bits,
		is_pinned, table_version, input ready);
	modport sink (input valid, ok, status, slot_index, page_generation, dirty_bits,
		is_pinned, table_version, output ready);
endinterface

// ----- rtl/core/prt_cfg_if.sv -----
`timescale 1ns / 1ps
interface prt_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] capacity_pages;

	modport source (output valid, capacity_pages, input ready);
	modport sink (input valid, capacity_pages, output ready);
endinterface

// ----- rtl/core/prt_mem.sv -----
`timescale 1ns / 1ps
module prt_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int WIDTH = 106
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ----- rtl/core/prt_scan.sv -----
`timescale 1ns / 1ps
module prt_scan #(
	parameter int SW = 6,
	parameter int KW = 32,
	parameter int WW = 106
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  prt_pkg::scan_ctl_t         ctl,
	input  logic [SW-1:0]              idx,
	input  logic [WW-1:0]              word,
	input  logic [KW-1:0]              key,
	output prt_pkg::scan_flags_t       flags,
	output logic [SW-1:0]              hit_slot,
	output logic [prt_pkg::GEN_W-1:0]  hit_gen,
	output logic [prt_pkg::LU_W-1:0]   hit_lu,
	output logic [prt_pkg::DIRTY_W-1:0] hit_dirty,
	output logic                       hit_pin,
	output logic [SW-1:0]              free_slot,
	output logic [SW-1:0]              vict_slot
);
	import prt_pkg::*;

	localparam int DIRTY_LSB = KEY_LSB + KW;
	localparam int PIN_BIT   = DIRTY_LSB + DIRTY_W;
	localparam int VLD_BIT   = PIN_BIT + 1;

	scan_flags_t        flags_q;
	logic [LU_W-1:0]    vict_lu_q;
	logic               e_vld, e_pin, match, empty, cand;
	logic [KW-1:0]      e_key;
	logic [DIRTY_W-1:0] e_dirty;
	logic [LU_W-1:0]    e_lu;
	logic [GEN_W-1:0]   e_gen;

	assign e_vld   = word[VLD_BIT];
	assign e_pin   = word[PIN_BIT];
	assign e_dirty = word[DIRTY_LSB +: DIRTY_W];
	assign e_key   = word[KEY_LSB +: KW];
	assign e_gen   = word[GEN_LSB +: GEN_W];
	assign e_lu    = word[LU_LSB +: LU_W];

	// one compare set, applied to each slot word read: key match, empty, older evictable entry
	assign match = e_vld && (e_key == key);
	assign empty = !e_vld;
	assign cand  = e_vld && !e_pin && (e_dirty == '0) && (!flags_q.vict || e_lu < vict_lu_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (ctl.clr) begin
			flags_q <= '0;
		end else if (ctl.vld) begin
			if (match) begin
				flags_q.hit <= 1'b1;
			end
			if (empty) begin
				flags_q.free <= 1'b1;
			end
			if (cand) begin
				flags_q.vict <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.vld && !ctl.clr) begin
			if (match && !flags_q.hit) begin
				hit_slot  <= idx;
				hit_gen   <= e_gen;
				hit_lu    <= e_lu;
				hit_dirty <= e_dirty;
				hit_pin   <= e_pin;
			end
			if (empty && !flags_q.free) begin
				free_slot <= idx;
			end
			if (cand) begin
				vict_slot <= idx;
				vict_lu_q <= e_lu;
			end
		end
	end

	assign flags = flags_q;
endmodule

// ----- rtl/core/lru_page_residency_table.sv -----
`timescale 1ns / 1ps
// Channel  Dir  Handshake      Payload
// req      in   valid/ready    op, page_key, pin_flag, plane_mask
// rsp      out  valid/ready    ok, status, slot_index, page_generation, dirty_bits,
//                              is_pinned, table_version
// cfg      in   valid/ready    capacity_pages (always ready)
//
// Search ops (ensure, set pin, mark dirty, ack clean, lookup) scan the active slots,
// one slot read per cycle from the entry memory (separate read and write ports).
// Clear writes every entry, one entry written per cycle. Unused op codes go straight
// to the result. After reset the entry memory is swept; req.ready stays low.
// One item at a time; a held result stalls only the S_DONE state of the next item.
module lru_page_residency_table #(
	parameter int SLOTS    = 64,
	parameter int KEY_BITS = 32
) (
	input logic     clk,
	input logic     arst_n,
	prt_req_if.sink   req,
	prt_rsp_if.source rsp,
	prt_cfg_if.sink   cfg
);
	import prt_pkg::*;

	`include "lru_page_residency_table_macros.svh"

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;  // slot index width
	localparam int CW = $clog2(SLOTS + 1);                // holds count up to SLOTS
	localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;  // stored key width
	localparam int WW = KEY_LSB + KW + DIRTY_W + 2;       // entry word width
	localparam logic [CW-1:0] ACT_RST = CW'((SLOTS < 64) ? SLOTS : 64);

	// capacity is clamped to 1..SLOTS when copied into the active slot count at a clear
	function automatic logic [CW-1:0] clamp_cap(input logic [6:0] c);
		logic [CW-1:0] r;
		if (c == '0) begin
			r = CW'(1);
		end else if (int'(c) > SLOTS) begin
			r = CW'(SLOTS);
		end else begin
			r = CW'(c);
		end
		return r;
	endfunction

	// control
	state_t        state_q, state_d;
	logic [CW-1:0] idx_q;
	logic          boot_q;
	logic          accept, go, scan_last, clr_last;

	// captured item
	op_t                op_q;
	logic [KW-1:0]      key_q;
	logic               pin_q;
	logic [DIRTY_W-1:0] planes_q;

	// table-wide state
	logic [6:0]       cap_q;
	logic [CW-1:0]    act_q, act_d;
	logic [LU_W-1:0]  use_q, use_d;
	logic [GEN_W-1:0] gen_q, gen_d;
	logic [31:0]      tab_q, tab_d;

	// result register
	logic               rsp_vld_q, rsp_ok_q, rsp_pin_q;
	status_t            rsp_st_q;
	logic [5:0]         rsp_slot_q;
	logic [GEN_W-1:0]   rsp_gen_q;
	logic [DIRTY_W-1:0] rsp_dirty_q;
	logic               r_ok, r_pin, out_load;
	status_t            r_st;
	logic [5:0]         r_slot;
	logic [GEN_W-1:0]   r_gen;
	logic [DIRTY_W-1:0] r_dirty;

	// memory and scan
	logic          mem_we, mem_re;
	logic [SW-1:0] mem_wa;
	logic [WW-1:0] mem_wd, mem_rd;
	logic          rd_vld_s1;
	logic [SW-1:0] rd_idx_s1;
	scan_ctl_t     sctl;
	scan_flags_t   sflags;
	logic [SW-1:0]      hit_slot, free_slot, vict_slot, new_slot;
	logic [GEN_W-1:0]   hit_gen;
	logic [LU_W-1:0]    hit_lu, touch_lu;
	logic [DIRTY_W-1:0] hit_dirty;
	logic               hit_pin;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign go        = !rsp_vld_q || rsp.ready;   // result register free this cycle
	assign scan_last = (idx_q == act_q - CW'(1));
	assign clr_last  = (idx_q == CW'(SLOTS - 1));
	assign touch_lu  = use_q + LU_W'(1);
	assign new_slot  = sflags.free ? free_slot : vict_slot;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.op == OP_CLEAR) begin
						state_d = S_CLR;
					end else if (req.op > OP_CLEAR) begin
						state_d = S_DONE;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_CLR: begin
				if (clr_last) begin
					state_d = boot_q ? S_IDLE : S_DONE;
				end
			end
			S_SCAN: begin
				if (scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: state_d = S_DONE;
			S_DONE: begin
				if (go) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs: memory port, scan control, and the final update
	always_comb begin
		mem_we   = 1'b0;
		mem_wa   = hit_slot;
		mem_wd   = {1'b1, hit_pin, hit_dirty, key_q, hit_gen, hit_lu};
		mem_re   = 1'b0;
		sctl.clr = accept;
		sctl.vld = rd_vld_s1;
		out_load = 1'b0;
		r_ok     = 1'b0;
		r_st     = ST_DONE;
		r_slot   = '0;
		r_gen    = '0;
		r_dirty  = '0;
		r_pin    = 1'b0;
		use_d    = use_q;
		gen_d    = gen_q;
		tab_d    = tab_q;
		act_d    = act_q;
		case (state_q)
			S_CLR: begin
				mem_we = 1'b1;
				mem_wa = idx_q[SW-1:0];
				mem_wd = '0;
			end
			S_SCAN: mem_re = 1'b1;
			S_DONE: begin
				out_load = go;
				case (op_q)
					OP_ENSURE: begin
						if (sflags.hit) begin
							mem_wd  = {1'b1, hit_pin | pin_q, hit_dirty, key_q, hit_gen, touch_lu};
							use_d   = touch_lu;
							r_ok    = 1'b1;
							r_st    = ST_HIT;
							r_slot  = SLOT_OUT_W'(hit_slot);
							r_gen   = hit_gen;
							r_dirty = hit_dirty;
							r_pin   = hit_pin | pin_q;
							mem_we  = go;
						end else if (sflags.free || sflags.vict) begin
							// place in lowest free slot, else over the least recently used clean, unpinned entry
							mem_wa  = new_slot;
							mem_wd  = {1'b1, pin_q, {DIRTY_W{1'b0}}, key_q, gen_q, touch_lu};
							use_d   = touch_lu;
							gen_d   = gen_q + GEN_W'(1);
							tab_d   = sflags.free ? tab_q + 32'd1 : tab_q + 32'd2;
							r_ok    = 1'b1;
							r_st    = sflags.free ? ST_FREE : ST_EVICT;
							r_slot  = SLOT_OUT_W'(new_slot);
							r_gen   = gen_q;
							r_pin   = pin_q;
							mem_we  = go;
						end else begin
							r_st = ST_NOSLOT;
						end
					end
					OP_SETPIN, OP_DIRTY, OP_CLEAN, OP_LOOKUP: begin
						if (!sflags.hit) begin
							r_st = ST_NOTFOUND;
						end else begin
							r_ok    = 1'b1;
							r_slot  = SLOT_OUT_W'(hit_slot);
							r_gen   = hit_gen;
							r_dirty = hit_dirty;
							r_pin   = hit_pin;
							if (op_q == OP_SETPIN) begin
								r_pin = pin_q;
								use_d = touch_lu;
								mem_wd = {1'b1, pin_q, hit_dirty, key_q, hit_gen, touch_lu};
								mem_we = go;
							end else if (op_q == OP_DIRTY) begin
								r_dirty = hit_dirty | planes_q;
								use_d   = touch_lu;
								mem_wd  = {1'b1, hit_pin, hit_dirty | planes_q, key_q, hit_gen,
									touch_lu};
								mem_we  = go;
							end else if (op_q == OP_CLEAN) begin
								// no touch: last use kept
								r_dirty = hit_dirty & ~planes_q;
								mem_wd  = {1'b1, hit_pin, hit_dirty & ~planes_q, key_q, hit_gen,
									hit_lu};
								mem_we  = go;
							end else begin
								r_st = ST_HIT;
							end
						end
					end
					OP_CLEAR: begin
						use_d = '0;
						tab_d = tab_q + 32'd1;
						act_d = clamp_cap(cap_q);
					end
					default: ;
				endcase
				if (!go) begin
					use_d = use_q;
					gen_d = gen_q;
					tab_d = tab_q;
					act_d = act_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			idx_q     <= '0;
			boot_q    <= 1'b1;
			cap_q     <= 7'd64;
			act_q     <= ACT_RST;
			use_q     <= '0;
			gen_q     <= '0;
			tab_q     <= '0;
			rsp_vld_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			use_q     <= use_d;
			gen_q     <= gen_d;
			tab_q     <= tab_d;
			act_q     <= act_d;
			rd_vld_s1 <= (state_q == S_SCAN);
			if (cfg.valid) begin
				cap_q <= cfg.capacity_pages;
			end
			if (accept) begin
				idx_q <= '0;
			end else if (state_q == S_CLR || state_q == S_SCAN) begin
				idx_q <= idx_q + CW'(1);
			end
			if (state_q == S_CLR && clr_last) begin
				boot_q <= 1'b0;
			end
			if (out_load) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q[SW-1:0];
		if (accept) begin
			op_q     <= op_t'(req.op);
			key_q    <= req.page_key[KW-1:0];
			pin_q    <= req.pin_flag;
			planes_q <= req.plane_mask;
		end
		if (out_load) begin
			rsp_ok_q    <= r_ok;
			rsp_st_q    <= r_st;
			rsp_slot_q  <= r_slot;
			rsp_gen_q   <= r_gen;
			rsp_dirty_q <= r_dirty;
			rsp_pin_q   <= r_pin;
		end
	end

	prt_mem #(
		.DEPTH (SLOTS),
		.AW    (SW),
		.WIDTH (WW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_wa),
		.wdata (mem_wd),
		.re    (mem_re),
		.raddr (idx_q[SW-1:0]),
		.rdata (mem_rd)
	);

	prt_scan #(
		.SW (SW),
		.KW (KW),
		.WW (WW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (sctl),
		.idx       (rd_idx_s1),
		.word      (mem_rd),
		.key       (key_q),
		.flags     (sflags),
		.hit_slot  (hit_slot),
		.hit_gen   (hit_gen),
		.hit_lu    (hit_lu),
		.hit_dirty (hit_dirty),
		.hit_pin   (hit_pin),
		.free_slot (free_slot),
		.vict_slot (vict_slot)
	);

	assign rsp.valid           = rsp_vld_q;
	assign rsp.ok              = rsp_ok_q;
	assign rsp.status          = rsp_st_q;
	assign rsp.slot_index      = rsp_slot_q;
	assign rsp.page_generation = rsp_gen_q;
	assign rsp.dirty_bits      = rsp_dirty_q;
	assign rsp.is_pinned       = rsp_pin_q;
	assign rsp.table_version   = tab_q;

	`PRT_ASSERT_IMP(a_scan_in_range, clk, arst_n, state_q == S_SCAN, idx_q < act_q)
	`PRT_ASSERT_IMP(a_act_range, clk, arst_n, 1'b1, (act_q != '0) && (act_q <= CW'(SLOTS)))
	`PRT_ASSERT_IMP(a_fail_clean, clk, arst_n, rsp_vld_q && !rsp_ok_q,
		(rsp_slot_q == '0) && (rsp_gen_q == '0) && (rsp_dirty_q == '0) && !rsp_pin_q)
	`PRT_ASSERT_IMP(a_ok_status, clk, arst_n, rsp_vld_q && rsp_ok_q,
		(rsp_st_q != ST_NOSLOT) && (rsp_st_q != ST_NOTFOUND))
	`PRT_ASSERT_NXT(a_busy_after_accept, clk, arst_n, accept, state_q != S_IDLE)
endmodule
